[sv/ctd_pkg.sv]
// Shared types and constants for the command TLV deframer.
package ctd_pkg;

	localparam int CMD_HDR_BYTES = 8;
	localparam logic [15:0] HDR_LEN = 16'(CMD_HDR_BYTES);
	localparam logic [15:0] NAME_FIRST = 16'd4;
	localparam logic [15:0] NAME_LAST = 16'd7;
	localparam logic [7:0] SKIP_RESET = 8'd12;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_DESC    = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_SUMMARY = 2'd2
	} ctd_kind_t;

	// Everything one input item causes: an optional descriptor or payload
	// result, optionally followed by the end-of-packet summary.
	typedef struct packed {
		logic        has_main;
		logic        has_sum;
		ctd_kind_t   main_kind;
		logic [31:0] name;
		logic [15:0] offset;
		logic [15:0] plen;
		logic [7:0]  pbyte;
		logic [15:0] pidx;
		logic        pend;
		logic [15:0] count;
	} ctd_rec_t;

endpackage

[sv/command_tlv_deframer_unit.sv]
// Top level: accepts one packet byte per cycle while the record queue has room.
// Results reach the ports through the record queue and then the output register.
// Throughput: one byte per cycle in while the queue has room; one result per pop out.
// Two-result bytes need a pop for each; the four-entry record queue absorbs this.
// Reset clears the parse state, the queue and the output stage; header skip returns to 12.
module command_tlv_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic [15:0] packet_length,
	input  logic        first_of_packet,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  kind,
	output logic [31:0] command_name,
	output logic [15:0] payload_offset,
	output logic [15:0] payload_length,
	output logic [7:0]  payload_byte,
	output logic [15:0] payload_index,
	output logic        payload_end,
	output logic [15:0] command_count,
	output logic        last_result
);

	ctd_pkg::ctd_rec_t front_rec, q_head;
	logic              front_valid, q_full, q_empty, q_pop;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	ctd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.accept          (push && !q_full),
		.data_byte       (data_byte),
		.packet_length   (packet_length),
		.first_of_packet (first_of_packet),
		.rec_valid       (front_valid),
		.rec             (front_rec)
	);

	ctd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid),
		.wr_data (front_rec),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_head),
		.empty   (q_empty)
	);

	ctd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_data         (q_head),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.pop            (pop),
		.empty          (empty),
		.kind           (kind),
		.command_name   (command_name),
		.payload_offset (payload_offset),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.payload_end    (payload_end),
		.command_count  (command_count),
		.last_result    (last_result)
	);

endmodule

[sv/ctd_front.sv]
// Front end: parse state, per-byte classification into result records.
module ctd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [7:0]        cfg_data,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic [15:0]       packet_length,
	input  logic              first_of_packet,
	output logic              rec_valid,
	output ctd_pkg::ctd_rec_t rec
);

	logic [7:0]  skip_q;
	logic [15:0] pos_q, start_q, len_q, cnt_q;
	logic [31:0] name_q;
	logic        stop_q;

	logic [15:0] p, start, len, cnt, rel;
	logic [31:0] name;
	logic        stop, in_range;
	logic [15:0] pos_n, start_n, len_n, cnt_n;
	logic [31:0] name_n;
	logic        stop_n;

	always_comb begin
		p     = first_of_packet ? 16'd0 : pos_q;
		start = first_of_packet ? {8'h00, skip_q} : start_q;
		len   = first_of_packet ? 16'd0 : len_q;
		cnt   = first_of_packet ? 16'd0 : cnt_q;
		name  = first_of_packet ? 32'd0 : name_q;
		stop  = first_of_packet ? 1'b0 : stop_q;

		pos_n   = (p != 16'hFFFF) ? p + 16'd1 : p;
		start_n = start;
		len_n   = len;
		cnt_n   = cnt;
		name_n  = name;
		stop_n  = stop;
		rec     = '0;
		rec.main_kind = ctd_pkg::KIND_DESC;

		in_range = p < packet_length;
		rel = p - start;

		if (in_range && !stop && p >= start) begin
			if (rel < ctd_pkg::HDR_LEN) begin
				if (rel == 16'd0) begin
					name_n = '0;
					len_n  = '0;
					// not even a full command header left in the packet
					if ({1'b0, start} + {1'b0, ctd_pkg::HDR_LEN} > {1'b0, packet_length})
						stop_n = 1'b1;
					else
						len_n = {data_byte, 8'h00};
				end else if (rel == 16'd1) begin
					len_n = len | {8'h00, data_byte};
					if (len_n < ctd_pkg::HDR_LEN ||
					    {1'b0, start} + {1'b0, len_n} > {1'b0, packet_length})
						stop_n = 1'b1;
				end else if (rel >= ctd_pkg::NAME_FIRST && rel <= ctd_pkg::NAME_LAST) begin
					name_n = {name[23:0], data_byte};
				end
				if (!stop_n && rel == ctd_pkg::HDR_LEN - 16'd1) begin
					cnt_n = cnt + 16'd1;
					rec.has_main  = 1'b1;
					rec.main_kind = ctd_pkg::KIND_DESC;
					rec.name      = name_n;
					rec.offset    = start + ctd_pkg::HDR_LEN;
					rec.plen      = len_n - ctd_pkg::HDR_LEN;
					// header-only command: next one starts right away
					if (len_n == ctd_pkg::HDR_LEN)
						start_n = start + len_n;
				end
			end else if (rel < len) begin
				rec.has_main  = 1'b1;
				rec.main_kind = ctd_pkg::KIND_PAYLOAD;
				rec.name      = name;
				rec.offset    = start + ctd_pkg::HDR_LEN;
				rec.plen      = len - ctd_pkg::HDR_LEN;
				rec.pbyte     = data_byte;
				rec.pidx      = rel - ctd_pkg::HDR_LEN;
				rec.pend      = (rel == len - 16'd1);
				if (rel == len - 16'd1)
					start_n = start + len;
			end else begin
				// packet length changed under a command
				stop_n = 1'b1;
			end
		end

		rec.has_sum = in_range && (p == packet_length - 16'd1);
		rec.count   = cnt_n;
		rec_valid   = accept && (rec.has_main || rec.has_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q  <= ctd_pkg::SKIP_RESET;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			name_q  <= '0;
			stop_q  <= 1'b0;
		end else begin
			if (cfg_valid)
				skip_q <= cfg_data;
			if (accept) begin
				pos_q   <= pos_n;
				start_q <= start_n;
				len_q   <= len_n;
				cnt_q   <= cnt_n;
				name_q  <= name_n;
				stop_q  <= stop_n;
			end
		end
	end

endmodule

[sv/ctd_queue.sv]
// Short record queue between the front end and the result sequencer.
module ctd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  ctd_pkg::ctd_rec_t wr_data,
	output logic              full,
	input  logic              rd_en,
	output ctd_pkg::ctd_rec_t rd_data,
	output logic              empty
);

	ctd_pkg::ctd_rec_t               mem_q [ctd_pkg::QUEUE_DEPTH];
	logic [ctd_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [ctd_pkg::QCNT_W-1:0] count_q;

	localparam logic [ctd_pkg::QPTR_W-1:0] PTR_LAST = ctd_pkg::QPTR_W'(ctd_pkg::QUEUE_DEPTH - 1);
	localparam logic [ctd_pkg::QCNT_W-1:0] CNT_FULL = ctd_pkg::QCNT_W'(ctd_pkg::QUEUE_DEPTH);

	logic do_wr, do_rd;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[sv/ctd_back.sv]
// Back end: holds one record and hands out its results one per pop.
module ctd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ctd_pkg::ctd_rec_t q_data,
	input  logic              q_empty,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output logic [1:0]        kind,
	output logic [31:0]       command_name,
	output logic [15:0]       payload_offset,
	output logic [15:0]       payload_length,
	output logic [7:0]        payload_byte,
	output logic [15:0]       payload_index,
	output logic              payload_end,
	output logic [15:0]       command_count,
	output logic              last_result
);

	ctd_pkg::ctd_rec_t rec_q;
	logic              valid_q;
	logic              sum_phase_q;

	logic cur_sum, taking, done, load;

	assign cur_sum = sum_phase_q || !rec_q.has_main;
	assign taking  = valid_q && pop;
	assign done    = taking && (cur_sum || !rec_q.has_sum);
	assign load    = (!valid_q || done) && !q_empty;
	assign q_pop   = load;
	assign empty   = !valid_q;

	always_comb begin
		command_count = rec_q.count;
		if (cur_sum) begin
			kind           = ctd_pkg::KIND_SUMMARY;
			command_name   = '0;
			payload_offset = '0;
			payload_length = '0;
			payload_byte   = '0;
			payload_index  = '0;
			payload_end    = 1'b0;
			last_result    = 1'b1;
		end else begin
			kind           = rec_q.main_kind;
			command_name   = rec_q.name;
			payload_offset = rec_q.offset;
			payload_length = rec_q.plen;
			payload_byte   = rec_q.pbyte;
			payload_index  = rec_q.pidx;
			payload_end    = rec_q.pend;
			last_result    = !rec_q.has_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			rec_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			sum_phase_q <= 1'b0;
		end else if (load) begin
			valid_q     <= 1'b1;
			sum_phase_q <= 1'b0;
		end else if (done) begin
			valid_q     <= 1'b0;
			sum_phase_q <= 1'b0;
		end else if (taking) begin
			sum_phase_q <= 1'b1;
		end
	end

endmodule
